/* rtl/hbp_pkg.sv */
// Shared constants and helper functions for the hybrid gshare/bimodal predictor.
// Used by hybrid_branch_predictor_core; no dependencies of its own.
package hbp_pkg;

  localparam int GS_BITS   = 10;
  localparam int HIST_BITS = 6;
  localparam int BM_BITS   = 9;
  localparam int CH_BITS   = 8;
  localparam int CTR_BITS  = 2;

  localparam int ADDR_BITS = 32;

  // Longest table index sets the length of the clearing sweep.
  localparam int CLR_BITS = (GS_BITS > BM_BITS)
                          ? ((GS_BITS > CH_BITS) ? GS_BITS : CH_BITS)
                          : ((BM_BITS > CH_BITS) ? BM_BITS : CH_BITS);

  typedef logic [CTR_BITS-1:0]  ctr_t;
  typedef logic [HIST_BITS-1:0] hist_t;
  typedef logic [GS_BITS-1:0]   gs_idx_t;
  typedef logic [BM_BITS-1:0]   bm_idx_t;
  typedef logic [CH_BITS-1:0]   ch_idx_t;
  typedef logic [CLR_BITS-1:0]  clr_t;

  localparam ctr_t CTR_MAX       = {CTR_BITS{1'b1}};
  localparam ctr_t CTR_THRESHOLD = CTR_MAX >> 1;
  localparam ctr_t COMP_INIT     = ctr_t'(2);
  localparam ctr_t CHOOSER_INIT  = ctr_t'(1);
  localparam ctr_t CHOOSER_PICK  = ctr_t'(1);

  // History alignment against the gshare index.
  localparam int HIST_UP = (GS_BITS >= HIST_BITS) ? (GS_BITS - HIST_BITS) : 0;
  localparam int HIST_DN = (GS_BITS >= HIST_BITS) ? 0 : (HIST_BITS - GS_BITS);
  localparam int ALIGN_BITS = GS_BITS + HIST_BITS;

  typedef logic [ALIGN_BITS-1:0] align_t;

  function automatic ctr_t sat_move(input ctr_t c, input logic up);
    ctr_t r;
    r = c;
    if (up) begin
      if (c != CTR_MAX) r = c + ctr_t'(1);
    end else begin
      if (c != ctr_t'(0)) r = c - ctr_t'(1);
    end
    return r;
  endfunction

  function automatic gs_idx_t gshare_index(input logic [ADDR_BITS-1:0] addr,
                                           input hist_t hist);
    align_t wide;
    wide = align_t'(hist);
    wide = (wide << HIST_UP) >> HIST_DN;
    return addr[2 +: GS_BITS] ^ wide[GS_BITS-1:0];
  endfunction

  function automatic hist_t hist_shift(input hist_t hist, input logic tkn);
    return (hist >> 1) | (hist_t'(tkn) << (HIST_BITS - 1));
  endfunction

endpackage

/* rtl/hbp_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module hbp_ram #(
  parameter int WIDTH     = 2,
  parameter int ADDR_BITS = 8
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic                 re,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  localparam int DEPTH = 1 << ADDR_BITS;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

/* rtl/hybrid_branch_predictor_core.sv */
// Hybrid gshare/bimodal branch predictor with a chooser table.
// Depends on hbp_pkg and hbp_ram (three counter tables).
//
//  channel | signals                          | carries
//  --------+----------------------------------+------------------------------------
//  in      | in_valid, in_ready               | branch_address, taken
//  out     | out_valid, out_ready             | prediction, used_gshare, mispredicted
//
// For each branch the tables are read at accept; in the update state the chosen
// component's counter and the chooser are written back and the result word is loaded.
// After reset a clearing pass writes 2^10 = 1024 entries (one per cycle, all
// three tables in parallel) before the first word is accepted.
// A result word not yet taken holds the write-back cycle of the next branch.
module hybrid_branch_predictor_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] branch_address,
  input  logic        taken,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        prediction,
  output logic        used_gshare,
  output logic        mispredicted
);

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;

  logic [1:0] state, state_next;
  hbp_pkg::clr_t clr;

  hbp_pkg::hist_t   hist;
  hbp_pkg::gs_idx_t gi;
  hbp_pkg::bm_idx_t bi;
  hbp_pkg::ch_idx_t ci;
  logic             taken_q;

  hbp_pkg::ctr_t gs_ctr, bm_ctr, ch_ctr;
  logic          accept, advance, clearing;
  logic          gs_pred, bm_pred, use_gs, final_pred;

  logic          gs_we, bm_we, ch_we;
  hbp_pkg::gs_idx_t gs_waddr;
  hbp_pkg::bm_idx_t bm_waddr;
  hbp_pkg::ch_idx_t ch_waddr;
  hbp_pkg::ctr_t gs_wdata, bm_wdata, ch_wdata;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign advance  = (state == ST_UPDATE) && (!out_valid || out_ready);
  assign clearing = (state == ST_CLEAR);

  assign gs_pred    = gs_ctr > hbp_pkg::CTR_THRESHOLD;
  assign bm_pred    = bm_ctr > hbp_pkg::CTR_THRESHOLD;
  assign use_gs     = ch_ctr > hbp_pkg::CHOOSER_PICK;
  assign final_pred = use_gs ? gs_pred : bm_pred;

  always_comb begin
    gs_we    = clearing || (advance && use_gs);
    bm_we    = clearing || (advance && !use_gs);
    ch_we    = clearing || advance;
    gs_waddr = clearing ? clr[hbp_pkg::GS_BITS-1:0] : gi;
    bm_waddr = clearing ? clr[hbp_pkg::BM_BITS-1:0] : bi;
    ch_waddr = clearing ? clr[hbp_pkg::CH_BITS-1:0] : ci;
    gs_wdata = clearing ? hbp_pkg::COMP_INIT : hbp_pkg::sat_move(gs_ctr, taken_q);
    bm_wdata = clearing ? hbp_pkg::COMP_INIT : hbp_pkg::sat_move(bm_ctr, taken_q);
    // Move the chooser toward the component that alone was right.
    priority if (clearing) begin
      ch_wdata = hbp_pkg::CHOOSER_INIT;
    end else if ((bm_pred == taken_q) && (gs_pred != taken_q)) begin
      ch_wdata = hbp_pkg::sat_move(ch_ctr, 1'b0);
    end else if ((bm_pred != taken_q) && (gs_pred == taken_q)) begin
      ch_wdata = hbp_pkg::sat_move(ch_ctr, 1'b1);
    end else begin
      ch_wdata = ch_ctr;
    end
  end

  hbp_ram #(.WIDTH(hbp_pkg::CTR_BITS), .ADDR_BITS(hbp_pkg::GS_BITS)) u_gs_ram (
    .clk   (clk),
    .we    (gs_we),
    .waddr (gs_waddr),
    .wdata (gs_wdata),
    .re    (accept),
    .raddr (hbp_pkg::gshare_index(branch_address, hist)),
    .rdata (gs_ctr)
  );

  hbp_ram #(.WIDTH(hbp_pkg::CTR_BITS), .ADDR_BITS(hbp_pkg::BM_BITS)) u_bm_ram (
    .clk   (clk),
    .we    (bm_we),
    .waddr (bm_waddr),
    .wdata (bm_wdata),
    .re    (accept),
    .raddr (branch_address[2 +: hbp_pkg::BM_BITS]),
    .rdata (bm_ctr)
  );

  hbp_ram #(.WIDTH(hbp_pkg::CTR_BITS), .ADDR_BITS(hbp_pkg::CH_BITS)) u_ch_ram (
    .clk   (clk),
    .we    (ch_we),
    .waddr (ch_waddr),
    .wdata (ch_wdata),
    .re    (accept),
    .raddr (branch_address[2 +: hbp_pkg::CH_BITS]),
    .rdata (ch_ctr)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (clr == {hbp_pkg::CLR_BITS{1'b1}}) state_next = ST_IDLE;
      ST_IDLE:   if (accept) state_next = ST_UPDATE;
      ST_UPDATE: if (advance) state_next = ST_IDLE;
      default:   state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr       <= '0;
      hist      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (clearing) clr <= clr + hbp_pkg::clr_t'(1);
      if (advance) begin
        hist      <= hbp_pkg::hist_shift(hist, taken_q);
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Hold the indexes and outcome of the branch in flight, and register the result word on write-back.
  always_ff @(posedge clk) begin
    if (accept) begin
      gi      <= hbp_pkg::gshare_index(branch_address, hist);
      bi      <= branch_address[2 +: hbp_pkg::BM_BITS];
      ci      <= branch_address[2 +: hbp_pkg::CH_BITS];
      taken_q <= taken;
    end
    if (advance) begin
      prediction   <= final_pred;
      used_gshare  <= use_gs;
      mispredicted <= final_pred != taken_q;
    end
  end

endmodule
